>>> hw/rtl/tmmb_pkg.sv
package tmmb_pkg;

	localparam int CordicSteps = 20;
	localparam int FullTurn    = 23040;
	localparam int QuarterTurn = 5760;

	// angle datapath: q30 with headroom
	typedef logic signed [33:0] ang_t;

	// quadrant after angle reduction
	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	// one cordic lane state (x, y, residual angle, quadrant)
	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
		quad_t              quad;
	} lane_t;

	typedef struct packed {
		lane_t pitch;
		lane_t yaw;
		lane_t roll;
	} trio_t;

	// side data that rides along the cordic chain
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] scale_z;
	} side_t;

	function automatic logic signed [33:0] atan_q30(input int i);
		logic signed [33:0] v;
		v = '0;
		unique case (i)
			0: v = 34'sd843314856;
			1: v = 34'sd497837829;
			2: v = 34'sd263043836;
			3: v = 34'sd133525158;
			4: v = 34'sd67021686;
			5: v = 34'sd33543515;
			6: v = 34'sd16775850;
			7: v = 34'sd8388437;
			8: v = 34'sd4194282;
			9: v = 34'sd2097149;
			10: v = 34'sd1048575;
			11: v = 34'sd524287;
			12: v = 34'sd262143;
			13: v = 34'sd131071;
			14: v = 34'sd65535;
			15: v = 34'sd32767;
			16: v = 34'sd16383;
			17: v = 34'sd8191;
			18: v = 34'sd4095;
			19: v = 34'sd2047;
			default: v = '0;
		endcase
		return v;
	endfunction

	// round half up from q60 to q30
	function automatic logic signed [33:0] rnd30(input logic signed [67:0] v);
		logic signed [67:0] t;
		t = v + 68'sd536870912;
		return t[63:30];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [67:0] t;
		logic signed [37:0] r;
		t = v + 68'sd536870912;
		r = t[67:30];
		if (r > 38'sd2147483647)
			return 32'sh7fffffff;
		else if (r < -38'sd2147483648)
			return 32'sh80000000;
		else
			return r[31:0];
	endfunction

endpackage

>>> hw/rtl/tmmb_prep.sv
module tmmb_prep (
	input  logic                clk,
	input  logic                en,
	input  logic signed [15:0]  pitch_angle,
	input  logic signed [15:0]  yaw_angle,
	input  logic signed [15:0]  roll_angle,
	output tmmb_pkg::trio_t     trio_s1
);

	function automatic tmmb_pkg::lane_t reduce(input logic signed [15:0] ang);
		logic signed [17:0] a;
		logic        [14:0] r;
		logic        [50:0] prod;
		tmmb_pkg::lane_t    l;
		// a 16-bit angle spans less than two turns either way, so two adds or one subtract wrap it
		a = 18'(ang);
		if (a < 0)
			a = a + 18'(tmmb_pkg::FullTurn);
		if (a < 0)
			a = a + 18'(tmmb_pkg::FullTurn);
		if (a >= 18'(tmmb_pkg::FullTurn))
			a = a - 18'(tmmb_pkg::FullTurn);
		if (a >= 18'(3 * tmmb_pkg::QuarterTurn)) begin
			l.quad = tmmb_pkg::QUAD_3;
			r = 15'(a - 18'(3 * tmmb_pkg::QuarterTurn));
		end else if (a >= 18'(2 * tmmb_pkg::QuarterTurn)) begin
			l.quad = tmmb_pkg::QUAD_2;
			r = 15'(a - 18'(2 * tmmb_pkg::QuarterTurn));
		end else if (a >= 18'(tmmb_pkg::QuarterTurn)) begin
			l.quad = tmmb_pkg::QUAD_1;
			r = 15'(a - 18'(tmmb_pkg::QuarterTurn));
		end else begin
			l.quad = tmmb_pkg::QUAD_0;
			r = a[14:0];
		end
		prod = 51'(r) * 51'd19190098067 + 51'd32768;
		l.x = 34'sd652032874;
		l.y = '0;
		l.z = $signed({1'b0, prod[48:16]});
		return l;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			trio_s1.pitch <= reduce(pitch_angle);
			trio_s1.yaw   <= reduce(yaw_angle);
			trio_s1.roll  <= reduce(roll_angle);
		end
	end

endmodule

>>> hw/rtl/tmmb_cordic_cell.sv
module tmmb_cordic_cell #(
	parameter int Step = 0
) (
	input  logic             clk,
	input  logic             en,
	input  tmmb_pkg::trio_t  trio_in,
	input  tmmb_pkg::side_t  side_in,
	output tmmb_pkg::trio_t  trio_q,
	output tmmb_pkg::side_t  side_q
);

	function automatic tmmb_pkg::lane_t rot(input tmmb_pkg::lane_t l);
		tmmb_pkg::lane_t o;
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		dx = l.y >>> Step;
		dy = l.x >>> Step;
		o = l;
		if (!l.z[33]) begin
			o.x = l.x - dx;
			o.y = l.y + dy;
			o.z = l.z - tmmb_pkg::atan_q30(Step);
		end else begin
			o.x = l.x + dx;
			o.y = l.y - dy;
			o.z = l.z + tmmb_pkg::atan_q30(Step);
		end
		return o;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			trio_q.pitch <= rot(trio_in.pitch);
			trio_q.yaw   <= rot(trio_in.yaw);
			trio_q.roll  <= rot(trio_in.roll);
			side_q       <= side_in;
		end
	end

endmodule

>>> hw/rtl/tmmb_matrix.sv
module tmmb_matrix (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  tmmb_pkg::trio_t     trio,
	input  tmmb_pkg::side_t     side,
	output logic                out_valid,
	output logic signed [31:0]  m00, m01, m02, m03,
	output logic signed [31:0]  m10, m11, m12, m13,
	output logic signed [31:0]  m20, m21, m22, m23
);

	typedef logic signed [33:0] q_t;

	function automatic q_t clampu(input q_t v);
		if (v > 34'sd1073741824)
			return 34'sd1073741824;
		else if (v < -34'sd1073741824)
			return -34'sd1073741824;
		else
			return v;
	endfunction

	function automatic logic [67:0] sc(input tmmb_pkg::lane_t l);
		q_t c, s;
		unique case (l.quad)
			tmmb_pkg::QUAD_0: begin c = l.x;  s = l.y;  end
			tmmb_pkg::QUAD_1: begin c = -l.y; s = l.x;  end
			tmmb_pkg::QUAD_2: begin c = -l.x; s = -l.y; end
			tmmb_pkg::QUAD_3: begin c = l.y;  s = -l.x; end
			default:          begin c = l.x;  s = l.y;  end
		endcase
		return {clampu(s), clampu(c)};
	endfunction

	function automatic logic signed [67:0] mul(input q_t a, input q_t b);
		return 68'(a) * 68'(b);
	endfunction

	// stage 1: quadrant fold and clamp
	q_t sx_s1, cx_s1, sy_s1, cy_s1, sz_s1, cz_s1;
	tmmb_pkg::side_t side_s1, side_s2, side_s3;
	logic [3:0] vld_q;

	// stage 2: sy*sx, cy*sx and plain products
	q_t sysx_s2, cysx_s2, sz_s2, cz_s2, sy_s2, cy_s2, sx_s2;
	q_t r02_s2, r10_s2, r11_s2, r22_s2;

	// stage 3: remaining rotation entries
	q_t r_s3 [3][3];

	always_ff @(posedge clk) begin
		if (en) begin
			{sx_s1, cx_s1} <= sc(trio.pitch);
			{sy_s1, cy_s1} <= sc(trio.yaw);
			{sz_s1, cz_s1} <= sc(trio.roll);
			side_s1 <= side;

			sysx_s2 <= tmmb_pkg::rnd30(mul(sy_s1, sx_s1));
			cysx_s2 <= tmmb_pkg::rnd30(mul(cy_s1, sx_s1));
			r02_s2  <= tmmb_pkg::rnd30(mul(sy_s1, cx_s1));
			r10_s2  <= tmmb_pkg::rnd30(mul(cx_s1, sz_s1));
			r11_s2  <= tmmb_pkg::rnd30(mul(cx_s1, cz_s1));
			r22_s2  <= tmmb_pkg::rnd30(mul(cy_s1, cx_s1));
			sx_s2 <= sx_s1; sy_s2 <= sy_s1; cy_s2 <= cy_s1;
			sz_s2 <= sz_s1; cz_s2 <= cz_s1;
			side_s2 <= side_s1;

			r_s3[0][0] <= tmmb_pkg::rnd30(mul(cy_s2, cz_s2) + mul(sysx_s2, sz_s2));
			r_s3[0][1] <= tmmb_pkg::rnd30(mul(sysx_s2, cz_s2) - mul(cy_s2, sz_s2));
			r_s3[0][2] <= r02_s2;
			r_s3[1][0] <= r10_s2;
			r_s3[1][1] <= r11_s2;
			r_s3[1][2] <= -sx_s2;
			r_s3[2][0] <= tmmb_pkg::rnd30(mul(cysx_s2, sz_s2) - mul(sy_s2, cz_s2));
			r_s3[2][1] <= tmmb_pkg::rnd30(mul(sy_s2, sz_s2) + mul(cysx_s2, cz_s2));
			r_s3[2][2] <= r22_s2;
			side_s3 <= side_s2;

			m00 <= tmmb_pkg::sat32(68'(r_s3[0][0]) * 68'(side_s3.scale_x));
			m01 <= tmmb_pkg::sat32(68'(r_s3[0][1]) * 68'(side_s3.scale_y));
			m02 <= tmmb_pkg::sat32(68'(r_s3[0][2]) * 68'(side_s3.scale_z));
			m10 <= tmmb_pkg::sat32(68'(r_s3[1][0]) * 68'(side_s3.scale_x));
			m11 <= tmmb_pkg::sat32(68'(r_s3[1][1]) * 68'(side_s3.scale_y));
			m12 <= tmmb_pkg::sat32(68'(r_s3[1][2]) * 68'(side_s3.scale_z));
			m20 <= tmmb_pkg::sat32(68'(r_s3[2][0]) * 68'(side_s3.scale_x));
			m21 <= tmmb_pkg::sat32(68'(r_s3[2][1]) * 68'(side_s3.scale_y));
			m22 <= tmmb_pkg::sat32(68'(r_s3[2][2]) * 68'(side_s3.scale_z));
			m03 <= side_s3.pos_x;
			m13 <= side_s3.pos_y;
			m23 <= side_s3.pos_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[2:0], in_valid};
		end
	end

	assign out_valid = vld_q[3];

endmodule

>>> hw/rtl/trs_model_matrix_builder.sv
// channel | handshake        | payload
// in      | valid, stall     | pos_*, *_angle, scale_*
// out     | out_valid, out_stall | m00..m23
// one beat per cycle when out_stall is low; each beat is registered through
// angle prep, 20 cordic cells and 4 matrix stages, all enabled together
// the whole chain freezes while a result waits under out_stall; stall mirrors it
// reset clears only the valid bits along the chain
module trs_model_matrix_builder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	output logic                stall,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	input  logic signed [15:0]  pitch_angle,
	input  logic signed [15:0]  yaw_angle,
	input  logic signed [15:0]  roll_angle,
	input  logic signed [31:0]  scale_x,
	input  logic signed [31:0]  scale_y,
	input  logic signed [31:0]  scale_z,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  m00, m01, m02, m03,
	output logic signed [31:0]  m10, m11, m12, m13,
	output logic signed [31:0]  m20, m21, m22, m23
);

	localparam int N = tmmb_pkg::CordicSteps;

	logic en;
	logic [N:0] vld_q;
	tmmb_pkg::trio_t trio [N+1];
	tmmb_pkg::side_t side [N+1];
	tmmb_pkg::side_t side_in;

	// global enable: advance unless a finished beat is held
	assign en    = !(out_valid && out_stall);
	assign stall = !en;

	assign side_in = '{pos_x: pos_x, pos_y: pos_y, pos_z: pos_z,
		scale_x: scale_x, scale_y: scale_y, scale_z: scale_z};

	tmmb_prep u_prep (
		.clk(clk), .en(en),
		.pitch_angle(pitch_angle), .yaw_angle(yaw_angle), .roll_angle(roll_angle),
		.trio_s1(trio[0])
	);

	always_ff @(posedge clk) begin
		if (en)
			side[0] <= side_in;
	end

	for (genvar g = 0; g < N; g++) begin : g_cell
		tmmb_cordic_cell #(.Step(g)) u_cell (
			.clk(clk), .en(en),
			.trio_in(trio[g]), .side_in(side[g]),
			.trio_q(trio[g+1]), .side_q(side[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[N-1:0], valid};
		end
	end

	tmmb_matrix u_matrix (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_q[N]), .trio(trio[N]), .side(side[N]),
		.out_valid(out_valid),
		.m00(m00), .m01(m01), .m02(m02), .m03(m03),
		.m10(m10), .m11(m11), .m12(m12), .m13(m13),
		.m20(m20), .m21(m21), .m22(m22), .m23(m23)
	);

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> out_valid) else $error("stall without held beat");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(m00) && $stable(m22))
		else $error("held result changed");
	a_chain_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!stall && valid |=> vld_q[0]) else $error("accepted beat lost");

endmodule

>>> tb/tb_trs_model_matrix_builder.sv
`timescale 1ns / 1ps
module tb_trs_model_matrix_builder;

	typedef struct {
		logic signed [31:0] m [12];
	} matrix_t;

	typedef struct {
		logic signed [31:0] pos [3];
		logic signed [15:0] ang [3];
		logic signed [31:0] scl [3];
	} xform_t;

	logic clk;
	logic arst_n;
	logic valid;
	logic stall;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic signed [15:0] pitch_angle, yaw_angle, roll_angle;
	logic signed [31:0] scale_x, scale_y, scale_z;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] m00, m01, m02, m03, m10, m11, m12, m13, m20, m21, m22, m23;

	matrix_t pending_matrices[$];
	int mismatch_count;
	int burst_left;
	int hold_off_cycles;

	trs_model_matrix_builder u_dut (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.pitch_angle(pitch_angle), .yaw_angle(yaw_angle), .roll_angle(roll_angle),
		.scale_x(scale_x), .scale_y(scale_y), .scale_z(scale_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.m00(m00), .m01(m01), .m02(m02), .m03(m03),
		.m10(m10), .m11(m11), .m12(m12), .m13(m13),
		.m20(m20), .m21(m21), .m22(m22), .m23(m23)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("tb_trs_model_matrix_builder: done, errors");
		$finish;
	end

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_q30(longint v);
		return (v + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic longint clamp_one(longint v);
		if (v > 64'sd1073741824)
			return 64'sd1073741824;
		if (v < -64'sd1073741824)
			return -64'sd1073741824;
		return v;
	endfunction

	function automatic void cordic_sincos(input logic signed [15:0] angle, output longint s,
			output longint c);
		longint arc_tab [20] = '{843314856, 497837829, 263043836, 133525158, 67021686,
			33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
			131071, 65535, 32767, 16383, 8191, 4095, 2047};
		longint a, r, z, x, y, dx, dy;
		tmmb_pkg::quad_t q;
		a = (longint'(angle) + 2 * tmmb_pkg::FullTurn) % tmmb_pkg::FullTurn;
		q = tmmb_pkg::quad_t'(a / tmmb_pkg::QuarterTurn);
		r = a % tmmb_pkg::QuarterTurn;
		z = longint'((64'(r) * 64'd19190098067 + 64'd32768) >> 16);
		x = 652032874;
		y = 0;
		for (int i = 0; i < tmmb_pkg::CordicSteps; i++) begin
			dx = shr_floor(y, i);
			dy = shr_floor(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= arc_tab[i];
			end else begin
				x += dx; y -= dy; z += arc_tab[i];
			end
		end
		case (q)
			tmmb_pkg::QUAD_0: begin c = x; s = y; end
			tmmb_pkg::QUAD_1: begin c = -y; s = x; end
			tmmb_pkg::QUAD_2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		c = clamp_one(c);
		s = clamp_one(s);
	endfunction

	function automatic logic signed [31:0] scale_entry(longint rot, logic signed [31:0] sc);
		logic signed [67:0] p;
		logic signed [67:0] v;
		p = 68'(rot) * 68'(sc) + 68'sd536870912;
		v = p >>> 30;
		if (v > 68'sd2147483647)
			return 32'sh7fffffff;
		if (v < -68'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic matrix_t build_model_matrix(xform_t t);
		longint sx, cx, sy, cy, sz, cz, sysx, cysx;
		longint rot [9];
		matrix_t res;
		cordic_sincos(t.ang[0], sx, cx);
		cordic_sincos(t.ang[1], sy, cy);
		cordic_sincos(t.ang[2], sz, cz);
		sysx = round_q30(sy * sx);
		cysx = round_q30(cy * sx);
		rot[0] = round_q30(cy * cz + sysx * sz);
		rot[1] = round_q30(sysx * cz - cy * sz);
		rot[2] = round_q30(sy * cx);
		rot[3] = round_q30(cx * sz);
		rot[4] = round_q30(cx * cz);
		rot[5] = -sx;
		rot[6] = round_q30(cysx * sz - sy * cz);
		rot[7] = round_q30(sy * sz + cysx * cz);
		rot[8] = round_q30(cy * cx);
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++)
				res.m[i * 4 + j] = scale_entry(rot[i * 3 + j], t.scl[j]);
			res.m[i * 4 + 3] = t.pos[i];
		end
		return res;
	endfunction

	// sends one beat, with bursty gaps in between
	task automatic send_xform(xform_t t);
		if (burst_left == 0) begin
			valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(negedge clk);
			burst_left = $urandom_range(20, 1);
		end
		burst_left--;
		valid <= 1'b1;
		pos_x <= t.pos[0]; pos_y <= t.pos[1]; pos_z <= t.pos[2];
		pitch_angle <= t.ang[0]; yaw_angle <= t.ang[1]; roll_angle <= t.ang[2];
		scale_x <= t.scl[0]; scale_y <= t.scl[1]; scale_z <= t.scl[2];
		@(posedge clk);
		while (stall) @(posedge clk);
		pending_matrices.push_back(build_model_matrix(t));
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] any_angle();
		case ($urandom_range(3, 0))
			0: return 16'(int'($urandom_range(46080, 0)) - 23040);
			1: return 16'(int'($urandom_range(4, 0)) * 5760 - 11520 + int'($urandom_range(2, 0)) - 1);
			default: return 16'(int'($urandom_range(2880, 0)) - 1440);
		endcase
	endfunction

	function automatic logic signed [31:0] any_word();
		case ($urandom_range(4, 0))
			0: return $urandom;
			1: return 32'(int'($urandom_range(8 << 16, 0)) - (4 << 16));
			2: return $urandom_range(1, 0) ? 32'sh7fffffff : 32'sh80000000;
			default: return 32'($urandom_range(3 << 16, 1 << 14));
		endcase
	endfunction

	function automatic xform_t random_xform();
		xform_t t;
		for (int k = 0; k < 3; k++) begin
			t.pos[k] = $urandom;
			t.ang[k] = any_angle();
			t.scl[k] = any_word();
		end
		return t;
	endfunction

	function automatic xform_t make_xform(logic signed [31:0] p, logic signed [15:0] ax,
			logic signed [15:0] ay, logic signed [15:0] az, logic signed [31:0] s);
		xform_t t;
		t.pos = '{p, ~p, p ^ 32'h5a5a5a5a};
		t.ang = '{ax, ay, az};
		t.scl = '{s, s, s};
		return t;
	endfunction

	task automatic wait_drained();
		valid <= 1'b0;
		while (pending_matrices.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic test_directed_extremes();
		send_xform(make_xform(32'h0, 16'sd0, 16'sd0, 16'sd0, 32'sh00010000));
		send_xform(make_xform(32'sh7fffffff, 16'sd23040, -16'sd23040, 16'sd23040,
			32'sh00010000));
		send_xform(make_xform(32'sh80000000, -16'sd23040, 16'sd23040, -16'sd23040,
			32'sh7fffffff));
		send_xform(make_xform(32'shffffffff, 16'sd5760, 16'sd11520, 16'sd17280,
			32'sh80000000));
		send_xform(make_xform(32'h12345678, -16'sd5760, -16'sd11520, -16'sd17280,
			32'sh7fffffff));
		send_xform(make_xform(32'h0, 16'sh7fff, 16'sh8000, 16'sh7fff, 32'sh80000000));
		send_xform(make_xform(32'h1, 16'sh8000, 16'sh7fff, 16'sh8000, 32'sh00000001));
		send_xform(make_xform(32'h2, 16'sd2880, 16'sd2880, 16'sd2880, -32'sh00010000));
		send_xform(make_xform(32'h3, 16'sd5759, 16'sd5761, -16'sd1, 32'sh00020000));
		send_xform(make_xform(32'h4, 16'h5555, 16'haaaa, 16'h5555, 32'h55555555));
		send_xform(make_xform(32'haaaaaaaa, 16'haaaa, 16'h5555, 16'haaaa, 32'haaaaaaaa));
		send_xform(make_xform(32'h5, 16'sd30000, -16'sd30000, 16'sd100, 32'sh40000000));
		wait_drained();
	endtask

	task automatic test_random_stream();
		for (int n = 0; n < 1200; n++) send_xform(random_xform());
		wait_drained();
	endtask

	// receiver holds off long enough that the pipeline fills and stalls input
	task automatic test_backpressure_fill();
		hold_off_cycles = 200;
		for (int n = 0; n < 300; n++) send_xform(random_xform());
		wait_drained();
	endtask

	initial begin
		out_stall = 1'b0;
		hold_off_cycles = 0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				out_stall <= 1'b1;
				hold_off_cycles--;
			end else if ($urandom_range(7, 0) < 2)
				out_stall <= 1'b1;
			else
				out_stall <= ($urandom_range(99, 0) < 3);
		end
	end

	initial begin
		matrix_t got;
		matrix_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.m = '{m00, m01, m02, m03, m10, m11, m12, m13, m20, m21, m22, m23};
				if (pending_matrices.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result beat at %0t", $realtime);
				end else begin
					want = pending_matrices.pop_front();
					for (int k = 0; k < 12; k++)
						if (got.m[k] !== want.m[k]) begin
							mismatch_count++;
							if (mismatch_count <= 10)
								$display("m%0d%0d: expected %h, got %h",
									k / 4, k % 4, want.m[k], got.m[k]);
						end
				end
			end
		end
	end

	initial begin
		mismatch_count = 0;
		burst_left = 0;
		arst_n = 1'b0;
		valid = 1'b0;
		{pos_x, pos_y, pos_z, scale_x, scale_y, scale_z} = '0;
		{pitch_angle, yaw_angle, roll_angle} = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed_extremes();
		test_random_stream();
		test_backpressure_fill();
		if (mismatch_count == 0 && pending_matrices.size() == 0)
			$display("tb_trs_model_matrix_builder: done, clean");
		else
			$display("tb_trs_model_matrix_builder: done, errors");
		$finish;
	end

endmodule
